FILE: src/fdf_pkg.sv
// ----------------------------------------------------------------------------
// fdf_pkg
// Shared constants and types for the fiber direction from flux pipeline.
// ----------------------------------------------------------------------------
package fdf_pkg;

	// normalized magnitudes land in [2^30, 2^31)
	localparam int NORM_MSB   = 30;
	// unit vectors for the angle test are Q30
	localparam int ANGLE_FRAC = 30;
	localparam int ANGLE_W    = ANGLE_FRAC + 2;
	// squared norm width
	localparam int NRM_W      = 64;
	// configuration data width
	localparam int CFG_W      = 16;
	// 1.0 in Q8.8
	localparam int TOL_ONE    = 256;

	typedef enum logic [1:0] {
		FLIP_NONE = 2'd0,
		FLIP_Y    = 2'd1,
		FLIP_Z    = 2'd2
	} flip_t;

	typedef enum logic [1:0] {
		CFG_COS_LIMIT = 2'd0,
		CFG_MAG_TOL   = 2'd1,
		CFG_CORR_EN   = 2'd2
	} cfg_idx_t;

endpackage

FILE: src/fdf_unit.sv
// ----------------------------------------------------------------------------
// fdf_unit
// Pipelined unit vector: normalize by shift, square, bitwise integer square
// root (one bit a stage), restoring divide (one quotient bit a stage).
// ----------------------------------------------------------------------------
module fdf_unit
	import fdf_pkg::*;
#(
	parameter int CW   = 33,
	parameter int FRAC = 30,
	parameter bit RND  = 1'b0,
	parameter int PW   = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [2:0][CW-1:0]    in_comp,
	input  logic [PW-1:0]         in_pay,
	output logic                  out_vld,
	output logic [2:0][FRAC+1:0]  out_comp,
	output logic [PW-1:0]         out_pay
);

	localparam int SHW = $clog2((CW > NORM_MSB + 1) ? CW : NORM_MSB + 1);
	localparam int NB  = NORM_MSB + 1;
	localparam int SQW = 2 * NB + 2;
	localparam int RW  = NB + 1;
	localparam int RS  = RW;
	localparam int QW  = FRAC + 1;
	localparam int OW  = FRAC + 2;
	localparam int DW  = FRAC + NORM_MSB + 3;

	// ---------------- stage 1: magnitudes and shift amount
	logic [2:0][CW-1:0] mag;
	logic [CW-1:0]      orv;
	logic [SHW-1:0]     msb;
	logic               right;
	logic [SHW-1:0]     amt;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = in_comp[i][CW-1] ? (~in_comp[i] + 1'b1) : in_comp[i];
		end
		orv = mag[0] | mag[1] | mag[2];
		msb = '0;
		for (int b = 0; b < CW; b++) begin
			if (orv[b]) msb = SHW'(b);
		end
		right = msb > SHW'(NORM_MSB);
		amt = right ? SHW'(msb - SHW'(NORM_MSB)) : SHW'(SHW'(NORM_MSB) - msb);
	end

	logic               vld_s1;
	logic [PW-1:0]      pay_s1;
	logic [2:0]         sgn_s1;
	logic [2:0][CW-1:0] mag_s1;
	logic               right_s1;
	logic [SHW-1:0]     amt_s1;

	// ---------------- stage 2: shift into [2^30, 2^31)
	logic [2:0][CW+NB-1:0] wide;
	logic [2:0][NB-1:0]    mn;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wide[i] = (CW + NB)'(mag_s1[i]);
			wide[i] = right_s1 ? (wide[i] >> amt_s1) : (wide[i] << amt_s1);
			mn[i] = wide[i][NB-1:0];
		end
	end

	logic               vld_s2;
	logic [PW-1:0]      pay_s2;
	logic [2:0]         sgn_s2;
	logic [2:0][NB-1:0] mn_s2;

	// ---------------- stage 3: squares
	logic               vld_s3;
	logic [PW-1:0]      pay_s3;
	logic [2:0]         sgn_s3;
	logic [2:0][NB-1:0] mn_s3;
	logic [2:0][2*NB-1:0] sq_s3;

	// ---------------- stage 4 and root stages
	logic           rt_vld_s [RS+1];
	logic [PW-1:0]  rt_pay_s [RS+1];
	logic [2:0]     rt_sgn_s [RS+1];
	logic [2:0][NB-1:0] rt_mn_s [RS+1];
	logic [SQW-1:0] rt_v_s   [RS+1];
	logic [SQW-1:0] rt_r_s   [RS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			rt_vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			rt_vld_s[0] <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s1   <= in_pay;
			sgn_s1   <= {in_comp[2][CW-1], in_comp[1][CW-1], in_comp[0][CW-1]};
			mag_s1   <= mag;
			right_s1 <= right;
			amt_s1   <= amt;

			pay_s2 <= pay_s1;
			sgn_s2 <= sgn_s1;
			mn_s2  <= mn;

			pay_s3 <= pay_s2;
			sgn_s3 <= sgn_s2;
			mn_s3  <= mn_s2;
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= mn_s2[i] * mn_s2[i];
			end

			rt_pay_s[0] <= pay_s3;
			rt_sgn_s[0] <= sgn_s3;
			rt_mn_s[0]  <= mn_s3;
			rt_v_s[0]   <= SQW'(sq_s3[0]) + SQW'(sq_s3[1]) + SQW'(sq_s3[2]);
			rt_r_s[0]   <= '0;
		end
	end

	for (genvar j = 0; j < RS; j++) begin : g_root
		localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (RS - 1 - j));
		logic [SQW-1:0] trial;
		logic [SQW-1:0] v_nx;
		logic [SQW-1:0] r_nx;

		always_comb begin
			trial = rt_r_s[j] + BIT;
			if (rt_v_s[j] >= trial) begin
				v_nx = rt_v_s[j] - trial;
				r_nx = (rt_r_s[j] >> 1) + BIT;
			end else begin
				v_nx = rt_v_s[j];
				r_nx = rt_r_s[j] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[j+1] <= 1'b0;
			end else if (en) begin
				rt_vld_s[j+1] <= rt_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_pay_s[j+1] <= rt_pay_s[j];
				rt_sgn_s[j+1] <= rt_sgn_s[j];
				rt_mn_s[j+1]  <= rt_mn_s[j];
				rt_v_s[j+1]   <= v_nx;
				rt_r_s[j+1]   <= r_nx;
			end
		end
	end

	// ---------------- divide: numerator setup, then one quotient bit a stage
	logic [RW-1:0] root;
	assign root = rt_r_s[RS][RW-1:0];

	logic               dv_vld_s [QW+1];
	logic [PW-1:0]      dv_pay_s [QW+1];
	logic [2:0]         dv_sgn_s [QW+1];
	logic [RW-1:0]      dv_n_s   [QW+1];
	logic [2:0][DW-1:0] dv_num_s [QW+1];
	logic [2:0][QW-1:0] dv_q_s   [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else if (en) begin
			dv_vld_s[0] <= rt_vld_s[RS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_pay_s[0] <= rt_pay_s[RS];
			dv_sgn_s[0] <= rt_sgn_s[RS];
			dv_n_s[0]   <= root;
			for (int i = 0; i < 3; i++) begin
				dv_num_s[0][i] <= (DW'(rt_mn_s[RS][i]) << FRAC)
					+ (RND ? DW'(root >> 1) : DW'(0));
			end
			dv_q_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int B = QW - 1 - k;
		logic [DW-1:0]      dsr;
		logic [2:0][DW-1:0] num_nx;
		logic [2:0][QW-1:0] q_nx;

		always_comb begin
			dsr = DW'(dv_n_s[k]) << B;
			for (int i = 0; i < 3; i++) begin
				if (dv_num_s[k][i] >= dsr) begin
					num_nx[i] = dv_num_s[k][i] - dsr;
					q_nx[i]   = dv_q_s[k][i] | (QW'(1) << B);
				end else begin
					num_nx[i] = dv_num_s[k][i];
					q_nx[i]   = dv_q_s[k][i];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_pay_s[k+1] <= dv_pay_s[k];
				dv_sgn_s[k+1] <= dv_sgn_s[k];
				dv_n_s[k+1]   <= dv_n_s[k];
				dv_num_s[k+1] <= num_nx;
				dv_q_s[k+1]   <= q_nx;
			end
		end
	end

	// ---------------- sign restore
	logic vld_so;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_so <= 1'b0;
		end else if (en) begin
			vld_so <= dv_vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_pay <= dv_pay_s[QW];
			for (int i = 0; i < 3; i++) begin
				out_comp[i] <= dv_sgn_s[QW][i] ? OW'(-{1'b0, dv_q_s[QW][i]})
					: OW'({1'b0, dv_q_s[QW][i]});
			end
		end
	end

	assign out_vld = vld_so;

endmodule

FILE: src/fdf_flip.sv
// ----------------------------------------------------------------------------
// fdf_flip
// Opposite-direction and magnitude tests of flux y and flux z against flux x,
// three stages: products, sums and compares, flip decision.
// ----------------------------------------------------------------------------
module fdf_flip
	import fdf_pkg::*;
#(
	parameter int PW = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_vld,
	input  logic                    act,
	input  logic [2:0][ANGLE_W-1:0] ux,
	input  logic [2:0][ANGLE_W-1:0] u1,
	input  logic [2:0][ANGLE_W-1:0] u2,
	input  logic [NRM_W-1:0]        nx2,
	input  logic [NRM_W-1:0]        n12,
	input  logic [NRM_W-1:0]        n22,
	input  logic [CFG_W-1:0]        cos_lim,
	input  logic [32:0]             tol_hi,
	input  logic [16:0]             tol_lo,
	input  logic                    lo_chk,
	input  logic [PW-1:0]           in_pay,
	output logic                    out_vld,
	output flip_t                   flip,
	output logic [PW-1:0]           out_pay
);

	localparam int PRW = 2 * ANGLE_W;
	localparam int HW  = NRM_W / 2;
	localparam int AW  = NRM_W + 16;
	localparam int BW  = 33 + NRM_W;
	localparam int CWD = 17 + NRM_W;

	// ---------------- stage 1: products
	logic                       vld_s1;
	logic                       act_s1;
	logic [PW-1:0]              pay_s1;
	logic signed [2:0][PRW-1:0] dp1_s1;
	logic signed [2:0][PRW-1:0] dp2_s1;
	logic [HW+32:0]             bh_s1;
	logic [HW+32:0]             bl_s1;
	logic [HW+16:0]             ch_s1;
	logic [HW+16:0]             cl_s1;
	logic [NRM_W-1:0]           n12_s1;
	logic [NRM_W-1:0]           n22_s1;

	// ---------------- stage 2: dot sums and magnitude compares
	logic signed [PRW-1:0] dot1;
	logic signed [PRW-1:0] dot2;
	logic signed [PRW-1:0] thr;
	logic [BW-1:0]         bsum;
	logic [CWD-1:0]        csum;
	logic [AW-1:0]         a1;
	logic [AW-1:0]         a2;
	logic                  ok1;
	logic                  ok2;

	always_comb begin
		dot1 = dp1_s1[0] + dp1_s1[1] + dp1_s1[2];
		dot2 = dp2_s1[0] + dp2_s1[1] + dp2_s1[2];
		thr  = $signed(PRW'({cos_lim, 45'b0}));
		bsum = {bh_s1, {HW{1'b0}}} + BW'(bl_s1);
		csum = {ch_s1, {HW{1'b0}}} + CWD'(cl_s1);
		a1   = {n12_s1, 16'b0};
		a2   = {n22_s1, 16'b0};
		ok1  = (dot1 <= -thr) && (BW'(a1) <= bsum) && (!lo_chk || csum <= CWD'(a1));
		ok2  = (dot2 <= -thr) && (BW'(a2) <= bsum) && (!lo_chk || csum <= CWD'(a2));
	end

	logic          vld_s2;
	logic          act_s2;
	logic [PW-1:0] pay_s2;
	logic          ok1_s2;
	logic          ok2_s2;

	logic vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1 <= act;
			pay_s1 <= in_pay;
			for (int i = 0; i < 3; i++) begin
				dp1_s1[i] <= $signed(ux[i]) * $signed(u1[i]);
				dp2_s1[i] <= $signed(ux[i]) * $signed(u2[i]);
			end
			bh_s1  <= tol_hi * nx2[NRM_W-1:HW];
			bl_s1  <= tol_hi * nx2[HW-1:0];
			ch_s1  <= tol_lo * nx2[NRM_W-1:HW];
			cl_s1  <= tol_lo * nx2[HW-1:0];
			n12_s1 <= n12;
			n22_s1 <= n22;

			act_s2 <= act_s1;
			pay_s2 <= pay_s1;
			ok1_s2 <= ok1;
			ok2_s2 <= ok2;

			out_pay <= pay_s2;
			if (!act_s2) flip <= FLIP_NONE;
			else if (ok1_s2) flip <= FLIP_Y;
			else if (ok2_s2) flip <= FLIP_Z;
			else flip <= FLIP_NONE;
		end
	end

	assign out_vld = vld_s3;

endmodule

FILE: src/fiber_direction_from_flux.sv
// ----------------------------------------------------------------------------
// fiber_direction_from_flux
// Per-point fiber direction from three heat fluxes, with opposite-flux fixup.
// ----------------------------------------------------------------------------
// Fully pipelined: one point per clock while m_axis_tready does not stall it.
// Most of the depth is in the unit-vector units, each a 32-stage square root
// followed by a one-bit-a-stage divider (31 stages for the Q30 angle test,
// DIR_FRAC_BITS + 1 for the output direction). Back-pressure stalls the whole
// pipeline; s_axis_tready follows m_axis_tready and the output register.
// Configuration is to be written only while the pipeline is empty; a write
// lands in its register, and tol_hi_q and tol_lo_q are registered from mag_tol_q.
// ----------------------------------------------------------------------------
module fiber_direction_from_flux
	import fdf_pkg::*;
#(
	parameter int GRAD_WIDTH    = 32,
	parameter int DIR_FRAC_BITS = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	// gx_x, gx_y, gx_z, gy_x, gy_y, gy_z, gz_x, gz_y, gz_z, conductivity (32b each)
	input  logic [319:0]      s_axis_tdata,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// dir_x, dir_y, dir_z (16b each)
	output logic [47:0]       m_axis_tdata,
	// valid_res (1b), flip_code (2b)
	output logic [2:0]        m_axis_tuser,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int FW  = GRAD_WIDTH + 1;
	localparam int SW  = FW + 2;
	localparam int DOW = DIR_FRAC_BITS + 2;
	localparam int FPW = 9 * FW;

	// ---------------- configuration
	logic [CFG_W-1:0] cos_lim_q;
	logic [CFG_W-1:0] mag_tol_q;
	logic             corr_en_q;
	logic [32:0]      tol_hi_q;
	logic [16:0]      tol_lo_q;
	logic             lo_chk_q;
	logic [16:0]      tol_p;
	logic [16:0]      tol_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_lim_q <= CFG_W'(16384);
			mag_tol_q <= CFG_W'(TOL_ONE);
			corr_en_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_COS_LIMIT: cos_lim_q <= cfg_data;
				CFG_MAG_TOL:   mag_tol_q <= cfg_data;
				CFG_CORR_EN:   corr_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// (1 + tol)^2 and (1 - tol)^2 in Q16
	assign tol_p = 17'(mag_tol_q) + 17'(TOL_ONE);
	assign tol_m = 17'(TOL_ONE) - 17'(mag_tol_q);

	always_ff @(posedge clk) begin
		tol_hi_q <= 33'(34'(tol_p) * 34'(tol_p));
		lo_chk_q <= mag_tol_q < CFG_W'(TOL_ONE);
		tol_lo_q <= (mag_tol_q < CFG_W'(TOL_ONE)) ? 17'(18'(tol_m) * 18'(tol_m)) : 17'(0);
	end

	// ---------------- global advance
	logic en;
	logic out_vld_q;

	assign en = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	// ---------------- stage 1: fluxes = -k * grad (k only gates to zero)
	logic [2:0][2:0][FW-1:0] f_in;
	logic                    kz;

	// sign extend before negating so the most negative gradient stays exact
	always_comb begin
		kz = s_axis_tdata[319:288] == 32'd0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				f_in[i][j] = kz ? FW'(0)
					: FW'(-$signed({s_axis_tdata[(3*i+j)*32 + GRAD_WIDTH - 1],
						s_axis_tdata[(3*i+j)*32 +: GRAD_WIDTH]}));
			end
		end
	end

	logic                    vld_s1;
	logic                    act_s1;
	logic [2:0][2:0][FW-1:0] f_s1;

	// ---------------- stage 2: squared components
	logic [2:0][2:0][GRAD_WIDTH-1:0] fm;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				fm[i][j] = GRAD_WIDTH'(f_s1[i][j][FW-1] ? -f_s1[i][j] : f_s1[i][j]);
			end
		end
	end

	logic                            vld_s2;
	logic                            act_s2;
	logic [2:0][2:0][FW-1:0]         f_s2;
	logic [2:0][2:0][2*GRAD_WIDTH-1:0] sq_s2;

	// ---------------- stage 3: squared norms
	logic                    vld_s3;
	logic                    act_s3;
	logic [2:0][2:0][FW-1:0] f_s3;
	logic [2:0][NRM_W-1:0]   nrm_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1   <= f_in;
			act_s1 <= corr_en_q && !kz && (f_in[0] != '0) && (f_in[1] != '0)
				&& (f_in[2] != '0);

			f_s2   <= f_s1;
			act_s2 <= act_s1;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					sq_s2[i][j] <= fm[i][j] * fm[i][j];
				end
			end

			f_s3   <= f_s2;
			act_s3 <= act_s2;
			for (int i = 0; i < 3; i++) begin
				nrm_s3[i] <= NRM_W'(sq_s2[i][0]) + NRM_W'(sq_s2[i][1])
					+ NRM_W'(sq_s2[i][2]);
			end
		end
	end

	// ---------------- Q30 unit vectors of the three fluxes
	logic                     u0_vld;
	logic                     u1_vld;
	logic                     u2_vld;
	logic [2:0][ANGLE_W-1:0]  u0;
	logic [2:0][ANGLE_W-1:0]  u1;
	logic [2:0][ANGLE_W-1:0]  u2;
	logic [FPW+NRM_W:0]       u0_pay;
	logic [NRM_W-1:0]         u1_nrm;
	logic [NRM_W-1:0]         u2_nrm;

	fdf_unit #(.CW(FW), .FRAC(ANGLE_FRAC), .RND(1'b0), .PW(FPW + NRM_W + 1)) u_unit0 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s3),
		.in_comp(f_s3[0]), .in_pay({act_s3, nrm_s3[0], f_s3}),
		.out_vld(u0_vld), .out_comp(u0), .out_pay(u0_pay)
	);

	fdf_unit #(.CW(FW), .FRAC(ANGLE_FRAC), .RND(1'b0), .PW(NRM_W)) u_unit1 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s3),
		.in_comp(f_s3[1]), .in_pay(nrm_s3[1]),
		.out_vld(u1_vld), .out_comp(u1), .out_pay(u1_nrm)
	);

	fdf_unit #(.CW(FW), .FRAC(ANGLE_FRAC), .RND(1'b0), .PW(NRM_W)) u_unit2 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s3),
		.in_comp(f_s3[2]), .in_pay(nrm_s3[2]),
		.out_vld(u2_vld), .out_comp(u2), .out_pay(u2_nrm)
	);

	// ---------------- flip decision
	logic                    fl_vld;
	flip_t                   fl_code;
	logic [FPW-1:0]          fl_pay;
	logic [2:0][2:0][FW-1:0] fl_f;

	fdf_flip #(.PW(FPW)) u_flip (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(u0_vld & u1_vld & u2_vld),
		.act(u0_pay[FPW+NRM_W]),
		.ux(u0), .u1(u1), .u2(u2),
		.nx2(u0_pay[FPW +: NRM_W]), .n12(u1_nrm), .n22(u2_nrm),
		.cos_lim(cos_lim_q), .tol_hi(tol_hi_q), .tol_lo(tol_lo_q), .lo_chk(lo_chk_q),
		.in_pay(u0_pay[FPW-1:0]),
		.out_vld(fl_vld), .flip(fl_code), .out_pay(fl_pay)
	);

	assign fl_f = fl_pay;

	// ---------------- flux sum
	logic [2:0][SW-1:0] sum;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sum[j] = SW'($signed(fl_f[0][j]))
				+ SW'($signed((fl_code == FLIP_Y) ? -fl_f[1][j] : fl_f[1][j]))
				+ SW'($signed((fl_code == FLIP_Z) ? -fl_f[2][j] : fl_f[2][j]));
		end
	end

	logic               vld_sa;
	logic [2:0][SW-1:0] sum_sa;
	logic               zero_sa;
	flip_t              flip_sa;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sa <= 1'b0;
		end else if (en) begin
			vld_sa <= fl_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_sa  <= sum;
			zero_sa <= sum == '0;
			flip_sa <= fl_code;
		end
	end

	// ---------------- output direction, rounded
	logic                 d_vld;
	logic [2:0][DOW-1:0]  d_comp;
	logic [2:0]           d_pay;
	logic [2:0][15:0]     dir;

	fdf_unit #(.CW(SW), .FRAC(DIR_FRAC_BITS), .RND(1'b1), .PW(3)) u_unit_dir (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_sa),
		.in_comp(sum_sa), .in_pay({zero_sa, flip_sa}),
		.out_vld(d_vld), .out_comp(d_comp), .out_pay(d_pay)
	);

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			dir[j] = d_pay[2] ? 16'd0 : 16'($signed(d_comp[j]));
		end
	end

	// ---------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= dir;
			m_axis_tuser <= {d_pay[1:0], !d_pay[2]};
		end
	end

	assign m_axis_tvalid = out_vld_q;

endmodule
